@@ src/rau_pkg.sv @@
package rau_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ORD_LESS    = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_GREATER = 2'd2
  } order_t;

  localparam int unsigned NUM_BITS = 33;
  localparam int unsigned DEN_BITS = 32;
  localparam int unsigned RAW_BITS = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_CHECK,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic do_mul;
    logic do_sum;
    logic gcd_start;
    logic gcd_step;
    logic div_start;
    logic div_step;
    logic div_sel_den;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip_reduce;
    logic gcd_done;
    logic div_done;
  } dp_stat_t;

endpackage

@@ src/rational_arithmetic_unit.sv @@
// Rational arithmetic unit: takes two signed fractions and an operation, forms
// the cross products, then reduces by the GCD of the magnitudes. One item is
// in flight at a time. Compare, unused codes and a zero numerator or
// denominator skip the reduction: the check state writes the result word.
// Reduced results go through the binary GCD loop and then two 64-step restoring
// divisions on the shared divider. A result waits in the output register until
// taken; the next input word is accepted the cycle after that.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int unsigned OPERAND_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // kind[2:0], a_num, a_den, b_num, b_den from bit 3 up, zero fill to bytes
  input  logic [((3+4*OPERAND_BITS+7)/8)*8-1:0] in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // res_num[32:0], res_den[64:33], res_valid[65], order[67:66], zeros up to 71
  output logic [71:0]               out_tdata
);

  localparam int unsigned OB = OPERAND_BITS;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [NUM_BITS-1:0] res_num;
  logic [DEN_BITS-1:0] res_den;
  logic res_valid;
  logic [1:0] order;

  rau_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire  (in_tvalid && in_tready),
    .out_fire (out_tvalid && out_tready),
    .stat, .cmd,
    .in_ready (in_tready),
    .out_valid(out_tvalid)
  );

  rau_datapath #(.OPERAND_BITS(OB)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .kind  (in_tdata[2:0]),
    .a_num (in_tdata[3+OB-1:3]),
    .a_den (in_tdata[3+2*OB-1:3+OB]),
    .b_num (in_tdata[3+3*OB-1:3+2*OB]),
    .b_den (in_tdata[3+4*OB-1:3+3*OB]),
    .res_num, .res_den, .res_valid, .order
  );

  assign out_tdata = {4'b0, order, res_valid, res_den, res_num};

endmodule

@@ src/rau_datapath.sv @@
module rau_datapath
  import rau_pkg::*;
#(
  parameter int unsigned OPERAND_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd,
  output dp_stat_t                   stat,
  input  logic [2:0]                 kind,
  input  logic [OPERAND_BITS-1:0]    a_num,
  input  logic [OPERAND_BITS-1:0]    a_den,
  input  logic [OPERAND_BITS-1:0]    b_num,
  input  logic [OPERAND_BITS-1:0]    b_den,
  output logic [NUM_BITS-1:0]        res_num,
  output logic [DEN_BITS-1:0]        res_den,
  output logic                       res_valid,
  output logic [1:0]                 order
);

  localparam int unsigned CW = 7;

  logic [2:0]                    kind_r;
  logic signed [OPERAND_BITS:0]  an_r, ad_r, bn_r, bd_r;
  logic signed [RAW_BITS-1:0]    p_r, q_r, d_r, n_r;
  logic [RAW_BITS-1:0]           x_r, y_r, g_r;
  logic [CW-1:0]                 k_r;
  logic [RAW_BITS-1:0]           rem_r, dvd_r;
  logic [CW-1:0]                 cnt_r;
  logic                          gcd_busy_r;
  logic [NUM_BITS-1:0]           res_num_r;
  logic [DEN_BITS-1:0]           res_den_r;
  logic                          res_valid_r;
  logic [1:0]                    order_r;
  logic [NUM_BITS-1:0]           qn_r;

  logic signed [OPERAND_BITS:0]  san, sad, sbn, sbd;
  logic signed [OPERAND_BITS:0]  m0a, m0b, m1a, m1b, m2a, m2b;
  logic [RAW_BITS-1:0]           nm, dm, rem_sh, rem_sub;
  logic                          rem_ge;

  always_comb begin
    san = $signed({a_num[OPERAND_BITS-1], a_num});
    sad = $signed({a_den[OPERAND_BITS-1], a_den});
    sbn = $signed({b_num[OPERAND_BITS-1], b_num});
    sbd = $signed({b_den[OPERAND_BITS-1], b_den});
    if (kind == OP_CMP) begin
      if (sad < 0) begin san = -san; sad = -sad; end
      if (sbd < 0) begin sbn = -sbn; sbd = -sbd; end
    end
  end

  // three cross products chosen by the operation
  always_comb begin
    m0a = an_r; m0b = bd_r;
    m1a = bn_r; m1b = ad_r;
    m2a = ad_r; m2b = bd_r;
    case (kind_r)
      OP_MUL: begin m0b = bn_r; end
      OP_DIV: begin m2b = bn_r; end
      default: ;
    endcase
  end

  assign nm = n_r[RAW_BITS-1] ? (~n_r + 1'b1) : n_r;
  assign dm = d_r[RAW_BITS-1] ? (~d_r + 1'b1) : d_r;

  assign rem_sh  = {rem_r[RAW_BITS-2:0], dvd_r[RAW_BITS-1]};
  assign rem_ge  = rem_sh >= g_r;
  assign rem_sub = rem_sh - g_r;

  assign stat.skip_reduce = (kind_r > OP_DIV) || (d_r == '0) || (n_r == '0);
  assign stat.gcd_done    = !gcd_busy_r;
  assign stat.div_done    = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcd_busy_r  <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cmd.load) begin
        kind_r <= kind;
        an_r <= san; ad_r <= sad; bn_r <= sbn; bd_r <= sbd;
      end
      if (cmd.do_mul) begin
        p_r <= RAW_BITS'(m0a * m0b);
        q_r <= RAW_BITS'(m1a * m1b);
        d_r <= RAW_BITS'(m2a * m2b);
      end
      if (cmd.do_sum) begin
        case (kind_r)
          OP_ADD:  n_r <= p_r + q_r;
          OP_SUB:  n_r <= p_r - q_r;
          default: n_r <= p_r;
        endcase
      end
      // binary GCD: strip common twos into k_r, then halve and subtract
      if (cmd.gcd_start) begin
        gcd_busy_r <= 1'b1;
        x_r <= nm;
        y_r <= dm;
        k_r <= '0;
      end else if (cmd.gcd_step && gcd_busy_r) begin
        if (x_r == y_r) begin
          gcd_busy_r <= 1'b0;
          g_r <= x_r << k_r;
        end else if (!x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (x_r > y_r) begin
          x_r <= (x_r - y_r) >> 1;
        end else begin
          y_r <= (y_r - x_r) >> 1;
        end
      end
      // restoring divider by g_r, numerator first, then denominator
      if (cmd.div_start) begin
        dvd_r <= nm;
        rem_r <= '0;
        cnt_r <= CW'(RAW_BITS);
      end else if (cmd.div_sel_den) begin
        qn_r  <= n_r[RAW_BITS-1] ? NUM_BITS'(~dvd_r + 1'b1) : dvd_r[NUM_BITS-1:0];
        dvd_r <= dm;
        rem_r <= '0;
        cnt_r <= CW'(RAW_BITS);
      end else if (cmd.div_step && cnt_r != '0) begin
        dvd_r <= {dvd_r[RAW_BITS-2:0], rem_ge};
        rem_r <= rem_ge ? rem_sub : rem_sh;
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.finish) begin
        if (kind_r == OP_CMP) begin
          res_num_r   <= '0;
          res_den_r   <= '0;
          res_valid_r <= (ad_r != 0) && (bd_r != 0);
          order_r     <= ($signed(p_r) < $signed(q_r)) ? ORD_LESS :
                         (p_r == q_r) ? ORD_EQUAL : ORD_GREATER;
        end else if (kind_r > OP_DIV) begin
          res_num_r   <= '0;
          res_den_r   <= '0;
          res_valid_r <= 1'b0;
          order_r     <= ORD_LESS;
        end else if (d_r == '0) begin
          res_num_r   <= n_r[NUM_BITS-1:0];
          res_den_r   <= '0;
          res_valid_r <= 1'b0;
          order_r     <= ORD_LESS;
        end else if (n_r == '0) begin
          res_num_r   <= '0;
          res_den_r   <= d_r[RAW_BITS-1] ? '1 : DEN_BITS'(1);
          res_valid_r <= 1'b1;
          order_r     <= ORD_LESS;
        end else begin
          res_num_r   <= qn_r;
          res_den_r   <= d_r[RAW_BITS-1] ? DEN_BITS'(~dvd_r + 1'b1)
                                         : dvd_r[DEN_BITS-1:0];
          res_valid_r <= 1'b1;
          order_r     <= ORD_LESS;
        end
      end
    end
  end

  assign res_num   = res_num_r;
  assign res_den   = res_den_r;
  assign res_valid = res_valid_r;
  assign order     = order_r;

endmodule

@@ src/rau_ctrl.sv @@
module rau_ctrl
  import rau_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_fire,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     in_ready,
  output logic     out_valid
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT);
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = in_fire;
        if (in_fire) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.do_mul = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        cmd.do_sum = 1'b1;
        state_nxt  = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.skip_reduce) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_OUT;
        end else begin
          cmd.gcd_start = 1'b1;
          state_nxt     = ST_GCD;
        end
      end
      ST_GCD: begin
        cmd.gcd_step  = !stat.gcd_done;
        cmd.div_start = stat.gcd_done;
        if (stat.gcd_done) state_nxt = ST_DIVN;
      end
      ST_DIVN: begin
        // numerator quotient ready: latch it and start on the denominator
        cmd.div_step    = !stat.div_done;
        cmd.div_sel_den = stat.div_done;
        if (stat.div_done) state_nxt = ST_DIVD;
      end
      ST_DIVD: begin
        cmd.div_step = !stat.div_done;
        cmd.finish   = stat.div_done;
        if (stat.div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_fire) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == ST_IDLE) else $error("load outside idle");
  a_out_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |=> in_ready) else $error("no return to idle");

endmodule
